>>> design/dual_random_hop_sine_oscillator_assert.svh
// assertion macros shared by the checker file
`ifndef DUAL_RANDOM_HOP_SINE_OSCILLATOR_ASSERT_SVH
`define DUAL_RANDOM_HOP_SINE_OSCILLATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DRHSO_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drhso check failed");

// next-cycle implication, sampled on clk, off while in reset
`define DRHSO_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("drhso check failed");

`endif

>>> design/drhso_pkg.sv
// shared constants, types and the quarter-wave sine table
`default_nettype none

package drhso_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_BITS      = 32;
	localparam int TAB_N           = 1 << SINE_TABLE_BITS;

	localparam int FREQ_BITS   = 48;
	localparam int DT_BITS     = 20;
	localparam int TIME_BITS   = 63;
	localparam int PROD_BITS   = FREQ_BITS + DT_BITS;
	localparam int PHASE_SHIFT = FREQ_BITS - PHASE_BITS;
	localparam int HALF_BITS   = FREQ_BITS / 2;

	localparam int AMP_BITS     = 15;
	localparam int MAG_BITS     = 15;
	localparam int RAND_BITS    = 32;
	localparam int PER_IN_BITS  = 24;
	localparam int PERIOD_BITS  = PER_IN_BITS + 1;
	localparam int OFFSET_BITS  = 16;
	localparam int ROUND_BITS   = AMP_BITS + MAG_BITS + 1;

	localparam int MUL_A_BITS = 32;
	localparam int MUL_B_BITS = 24;
	localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;

	localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_AMP_YAW    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_AMP_PITCH  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_MIN = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_SPN = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_GAP    = 3'd5;

	localparam logic [FREQ_BITS-1:0] FREQ_MAX = '1;
	localparam logic [MAG_BITS-1:0]  MAG_MAX  = '1;

	typedef logic [MAG_BITS-1:0] sine_tab_t [TAB_N];

	typedef struct packed {
		logic                   start;
		logic [PERIOD_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [FREQ_BITS-1:0] quot;
	} div_rsp_t;

	// taylor series in horner form, q30 radians in, q15 out
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t   tab;
		logic [63:0] q30_one;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] e;
		q30_one = 64'd1 << 30;
		for (int k = 0; k < TAB_N; k++) begin
			x  = (64'(k) * 64'd1686629713) >> SINE_TABLE_BITS;
			x2 = (x * x) >> 30;
			t  = q30_one;
			t  = q30_one - (((x2 * t) >> 30) / 64'd110);
			t  = q30_one - (((x2 * t) >> 30) / 64'd72);
			t  = q30_one - (((x2 * t) >> 30) / 64'd42);
			t  = q30_one - (((x2 * t) >> 30) / 64'd20);
			t  = q30_one - (((x2 * t) >> 30) / 64'd6);
			s  = (x * t) >> 30;
			e  = (s + 64'd16384) >> 15;
			tab[k] = (e > 64'd32767) ? MAG_MAX : e[MAG_BITS-1:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

>>> design/dual_random_hop_sine_oscillator.sv
// dual random-hop sine oscillator: yaw/pitch nco phases, quarter-wave sine, random period redraw
// sequence: an applied step checks the time step, then for yaw and then pitch multiplies,
// accumulates, advances the phase, reads the sine and rounds; then any oscillator that wrapped
// redraws its frequency on the 48-step restoring divider that both oscillators share in turn;
// a disabled or skipped step goes straight to the result; one transaction in flight at a time
// reset: async active low; registers to defaults, phases, frequencies and last time cleared
`default_nettype none

module dual_random_hop_sine_oscillator
	import drhso_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// input transaction
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [TIME_BITS-1:0]       now_us,
	input  logic [RAND_BITS-1:0]       rand_yaw,
	input  logic [RAND_BITS-1:0]       rand_pitch,
	// result transaction
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       applied,
	output logic signed [OFFSET_BITS-1:0] yaw_offset,
	output logic signed [OFFSET_BITS-1:0] pitch_offset,
	output logic                       yaw_rehopped,
	output logic                       pitch_rehopped,
	// register writes
	input  logic                       cfg_we,
	input  logic [CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ACC,
		ST_PHASE,
		ST_SIN,
		ST_ROUND,
		ST_DRAW_SEL,
		ST_DRAW_MUL,
		ST_DRAW_DIV,
		ST_DRAW_WAIT,
		ST_FINISH
	} state_t;

	// sequencer and architectural state
	state_t                 state_q;
	logic                   sel_q;          // 0 yaw, 1 pitch
	logic                   enable_q;
	logic [AMP_BITS-1:0]    amp_yaw_q;
	logic [AMP_BITS-1:0]    amp_pitch_q;
	logic [PER_IN_BITS-1:0] per_min_q;
	logic [PER_IN_BITS-1:0] per_span_q;
	logic [DT_BITS-1:0]     max_gap_q;
	logic [PHASE_BITS-1:0]  yaw_phase_q;
	logic [PHASE_BITS-1:0]  pitch_phase_q;
	logic [FREQ_BITS-1:0]   yaw_freq_q;
	logic [FREQ_BITS-1:0]   pitch_freq_q;
	logic                   freq_loaded_q;
	logic [TIME_BITS-1:0]   last_time_q;
	logic                   have_last_q;
	logic                   draw_y_q;
	logic                   draw_p_q;

	// working result, then the output register
	logic                   res_applied_q;
	logic [OFFSET_BITS-1:0] res_yaw_q;
	logic [OFFSET_BITS-1:0] res_pitch_q;
	logic                   res_wy_q;
	logic                   res_wp_q;
	logic                   out_valid_q;
	logic                   applied_q;
	logic [OFFSET_BITS-1:0] yaw_off_q;
	logic [OFFSET_BITS-1:0] pitch_off_q;
	logic                   yaw_hop_q;
	logic                   pitch_hop_q;

	// datapath registers
	logic [TIME_BITS-1:0]   now_q;
	logic [RAND_BITS-1:0]   ry_q;
	logic [RAND_BITS-1:0]   rp_q;
	logic [DT_BITS-1:0]     dt_q;
	logic [MUL_P_BITS-1:0]  mul_q;
	logic [PROD_BITS-1:0]   acc_q;
	logic                   neg_q;
	logic [MAG_BITS-1:0]    mag_q;

	logic                   accept_in;
	logic [TIME_BITS-1:0]   dt_full;
	logic                   gap_bad;
	logic [FREQ_BITS-1:0]   freq_sel;
	logic [PHASE_BITS-1:0]  phase_sel;
	logic [AMP_BITS-1:0]    amp_sel;
	logic [RAND_BITS-1:0]   rand_sel;
	logic [PHASE_BITS-1:0]  delta;
	logic [PHASE_BITS:0]    phase_sum;
	logic                   wrap;
	logic [1:0]             quad;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [SINE_TABLE_BITS:0]   ridx;
	logic [MAG_BITS-1:0]    mag;
	logic [ROUND_BITS-1:0]  rsum;
	logic [OFFSET_BITS-1:0] rmag;
	logic [OFFSET_BITS-1:0] off_val;
	logic [MUL_A_BITS-1:0]  mul_a;
	logic [MUL_B_BITS-1:0]  mul_b;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept_in = in_valid && in_ready;

	// time step check: zero, negative or too large steps are skipped
	assign dt_full = now_q - last_time_q;
	assign gap_bad = (dt_full == '0) || (|dt_full[TIME_BITS-1:DT_BITS])
		|| (dt_full[DT_BITS-1:0] > max_gap_q);

	assign freq_sel  = sel_q ? pitch_freq_q  : yaw_freq_q;
	assign phase_sel = sel_q ? pitch_phase_q : yaw_phase_q;
	assign amp_sel   = sel_q ? amp_pitch_q   : amp_yaw_q;
	assign rand_sel  = sel_q ? rp_q          : ry_q;

	// phase advance: freq*dt scaled to phase units; product bits above one turn also wrap
	assign delta     = acc_q[PHASE_SHIFT +: PHASE_BITS];
	assign phase_sum = {1'b0, phase_sel} + {1'b0, delta};
	assign wrap      = phase_sum[PHASE_BITS] || (|acc_q[PROD_BITS-1:FREQ_BITS]);

	// quadrant fold of the new phase; pitch takes cosine, i.e. one quadrant ahead
	assign quad = phase_sum[PHASE_BITS-1 -: 2] + {1'b0, sel_q};
	assign idx  = phase_sum[PHASE_BITS-3 -: SINE_TABLE_BITS];
	assign ridx = (SINE_TABLE_BITS+1)'(TAB_N) - {1'b0, idx};

	always_comb begin
		if (quad[0]) begin
			// reflected index at full table size is the peak
			mag = ridx[SINE_TABLE_BITS] ? MAG_MAX : SINE_TAB[ridx[SINE_TABLE_BITS-1:0]];
		end else begin
			mag = SINE_TAB[idx];
		end
	end

	// round half away from zero, then apply sign
	assign rsum    = mul_q[ROUND_BITS-2:0] + ROUND_BITS'(1 << (MAG_BITS - 1));
	assign rmag    = OFFSET_BITS'(rsum >> MAG_BITS);
	assign off_val = neg_q ? (OFFSET_BITS'(0) - rmag) : rmag;

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_MUL_LO: begin
				mul_a = MUL_A_BITS'(dt_q);
				mul_b = freq_sel[HALF_BITS-1:0];
			end
			ST_MUL_HI: begin
				mul_a = MUL_A_BITS'(dt_q);
				mul_b = freq_sel[FREQ_BITS-1:HALF_BITS];
			end
			ST_SIN: begin
				mul_a = MUL_A_BITS'(amp_sel);
				mul_b = MUL_B_BITS'(mag_q);
			end
			ST_DRAW_MUL: begin
				mul_a = rand_sel;
				mul_b = per_span_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// period = min + rand*span/2^32, handed to the divider
	assign div_req.start   = (state_q == ST_DRAW_DIV);
	assign div_req.divisor = {1'b0, per_min_q} + {1'b0, mul_q[MUL_P_BITS-1 -: PER_IN_BITS]};

	drhso_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (accept_in) begin
			now_q <= now_us;
			ry_q  <= rand_yaw;
			rp_q  <= rand_pitch;
		end
		if (state_q == ST_CHECK) begin
			dt_q <= dt_full[DT_BITS-1:0];
		end
		// low partial product lands first, high one is added shifted
		if (state_q == ST_MUL_HI) begin
			acc_q <= PROD_BITS'(mul_q[DT_BITS+HALF_BITS-1:0]);
		end else if (state_q == ST_ACC) begin
			acc_q <= acc_q + {mul_q[DT_BITS+HALF_BITS-1:0], HALF_BITS'(0)};
		end
		// sine table read with registered data, addressed by the new phase
		if (state_q == ST_PHASE) begin
			mag_q <= mag;
			neg_q <= quad[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sel_q         <= 1'b0;
			enable_q      <= 1'b1;
			amp_yaw_q     <= AMP_BITS'(3840);
			amp_pitch_q   <= AMP_BITS'(2560);
			per_min_q     <= PER_IN_BITS'(1500000);
			per_span_q    <= PER_IN_BITS'(4500000);
			max_gap_q     <= DT_BITS'(100000);
			yaw_phase_q   <= '0;
			pitch_phase_q <= '0;
			yaw_freq_q    <= '0;
			pitch_freq_q  <= '0;
			freq_loaded_q <= 1'b0;
			last_time_q   <= '0;
			have_last_q   <= 1'b0;
			draw_y_q      <= 1'b0;
			draw_p_q      <= 1'b0;
			res_applied_q <= 1'b0;
			res_yaw_q     <= '0;
			res_pitch_q   <= '0;
			res_wy_q      <= 1'b0;
			res_wp_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			applied_q     <= 1'b0;
			yaw_off_q     <= '0;
			pitch_off_q   <= '0;
			yaw_hop_q     <= 1'b0;
			pitch_hop_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						res_applied_q <= 1'b0;
						res_yaw_q     <= '0;
						res_pitch_q   <= '0;
						res_wy_q      <= 1'b0;
						res_wp_q      <= 1'b0;
						state_q       <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!enable_q) begin
						state_q <= ST_FINISH;
					end else if (!have_last_q) begin
						// first transaction only records time and loads frequencies once
						last_time_q <= now_q;
						have_last_q <= 1'b1;
						if (!freq_loaded_q) begin
							draw_y_q      <= 1'b1;
							draw_p_q      <= 1'b1;
							freq_loaded_q <= 1'b1;
						end
						state_q <= ST_DRAW_SEL;
					end else begin
						last_time_q <= now_q;
						if (gap_bad) begin
							state_q <= ST_FINISH;
						end else begin
							res_applied_q <= 1'b1;
							sel_q         <= 1'b0;
							state_q       <= ST_MUL_LO;
						end
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_ACC;
				ST_ACC:    state_q <= ST_PHASE;
				ST_PHASE: begin
					if (sel_q) begin
						pitch_phase_q <= phase_sum[PHASE_BITS-1:0];
						res_wp_q      <= wrap;
						draw_p_q      <= wrap;
					end else begin
						yaw_phase_q <= phase_sum[PHASE_BITS-1:0];
						res_wy_q    <= wrap;
						draw_y_q    <= wrap;
					end
					state_q <= ST_SIN;
				end
				ST_SIN: state_q <= ST_ROUND;
				ST_ROUND: begin
					if (sel_q) begin
						res_pitch_q <= off_val;
						state_q     <= ST_DRAW_SEL;
					end else begin
						res_yaw_q <= off_val;
						sel_q     <= 1'b1;
						state_q   <= ST_MUL_LO;
					end
				end
				ST_DRAW_SEL: begin
					priority if (draw_y_q) begin
						sel_q   <= 1'b0;
						state_q <= ST_DRAW_MUL;
					end else if (draw_p_q) begin
						sel_q   <= 1'b1;
						state_q <= ST_DRAW_MUL;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_DRAW_MUL: state_q <= ST_DRAW_DIV;
				ST_DRAW_DIV: state_q <= ST_DRAW_WAIT;
				ST_DRAW_WAIT: begin
					if (div_rsp.done) begin
						if (sel_q) begin
							pitch_freq_q <= div_rsp.quot;
							draw_p_q     <= 1'b0;
						end else begin
							yaw_freq_q <= div_rsp.quot;
							draw_y_q   <= 1'b0;
						end
						state_q <= ST_DRAW_SEL;
					end
				end
				ST_FINISH: begin
					// result register frees up in the same cycle it is taken
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						applied_q   <= res_applied_q;
						yaw_off_q   <= res_yaw_q;
						pitch_off_q <= res_pitch_q;
						yaw_hop_q   <= res_wy_q;
						pitch_hop_q <= res_wp_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// register writes must arrive only while idle; the block itself does not enforce this
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENABLE: begin
						enable_q    <= cfg_data[0];
						have_last_q <= 1'b0;
						if (!cfg_data[0]) begin
							yaw_phase_q   <= '0;
							pitch_phase_q <= '0;
						end
					end
					REG_AMP_YAW:    amp_yaw_q   <= cfg_data[AMP_BITS-1:0];
					REG_AMP_PITCH:  amp_pitch_q <= cfg_data[AMP_BITS-1:0];
					REG_PERIOD_MIN: per_min_q   <= cfg_data[PER_IN_BITS-1:0];
					REG_PERIOD_SPN: per_span_q  <= cfg_data[PER_IN_BITS-1:0];
					REG_MAX_GAP:    max_gap_q   <= cfg_data[DT_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign applied        = applied_q;
	assign yaw_offset     = yaw_off_q;
	assign pitch_offset   = pitch_off_q;
	assign yaw_rehopped   = yaw_hop_q;
	assign pitch_rehopped = pitch_hop_q;

endmodule

`default_nettype wire

>>> design/drhso_div.sv
// restoring divider: 2^48 / period, one quotient bit per cycle
`default_nettype none

module drhso_div
	import drhso_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_BITS = $clog2(FREQ_BITS + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [PERIOD_BITS-1:0] rem_q;
	logic [PERIOD_BITS-1:0] dvs_q;
	logic [FREQ_BITS-1:0]   quot_q;

	logic [PERIOD_BITS:0]   rem2;
	logic [PERIOD_BITS:0]   diff;
	logic                   fits;
	logic                   tiny;

	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, dvs_q};
	assign fits = rem2 >= {1'b0, dvs_q};
	// period of 0 or 1 saturates
	assign tiny = req.divisor <= PERIOD_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= !tiny;
				done_q <= tiny;
				cnt_q  <= CNT_BITS'(FREQ_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// top numerator bit already brought in: remainder starts at one
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= PERIOD_BITS'(1);
			dvs_q  <= req.divisor;
			quot_q <= FREQ_MAX;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[PERIOD_BITS-1:0] : rem2[PERIOD_BITS-1:0];
			quot_q <= {quot_q[FREQ_BITS-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

>>> design/drhso_chk.sv
// port-level checker for the oscillator, bound to the top level
`default_nettype none

`include "dual_random_hop_sine_oscillator_assert.svh"

module drhso_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        applied,
	input logic [15:0] yaw_offset,
	input logic [15:0] pitch_offset,
	input logic        yaw_rehopped,
	input logic        pitch_rehopped
);

	// one transaction in flight at a time
	`DRHSO_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// a skipped step carries an all-zero result
	`DRHSO_ASSERT_NOW(a_skip_zero, out_valid && !applied,
		yaw_offset == 16'd0 && pitch_offset == 16'd0 && !yaw_rehopped && !pitch_rehopped)

	// a redraw only happens on an applied step
	`DRHSO_ASSERT_NOW(a_hop_applied, out_valid && (yaw_rehopped || pitch_rehopped), applied)

	// a stalled result is held
	`DRHSO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind dual_random_hop_sine_oscillator drhso_chk u_chk (.*);

`default_nettype wire
